// ----- rtl/svk_pkg.sv -----
// shared widths, register indexes and the divider input bundle for the stress pipeline
package svk_pkg;

    localparam int FW   = 32;   // entry of F, Q16.16
    localparam int EW   = 49;   // strain entry
    localparam int TW   = 51;   // strain trace
    localparam int MTW  = 82;   // 2*mu*E
    localparam int LTW  = 83;   // lambda*tr
    localparam int SAW  = 84;   // stress sum before shift
    localparam int SW   = 68;   // second Piola-Kirchhoff entry
    localparam int FSAW = 100;  // F*S sum before shift
    localparam int FSW  = 84;   // F*S entry
    localparam int NAW  = 118;  // F*S*F^T sum before shift
    localparam int NW   = 102;  // F*S*F^T entry
    localparam int MW   = 65;   // 2x2 minor of F
    localparam int DTW  = 97;   // one cofactor term
    localparam int DETW = 99;   // determinant, Q51.48
    localparam int DW   = 67;   // |det| truncated to Q51.16
    localparam int QW   = 32;   // quotient bits
    localparam int NSTEP = QW;

    localparam logic [7:0] REG_LAMBDA = 8'd0;
    localparam logic [7:0] REG_MU     = 8'd1;

    localparam logic [QW-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [QW-1:0] SAT_MIN = 32'h8000_0000;

    typedef logic signed [NW-1:0] nval_t;

    typedef struct packed {
        logic          valid;
        logic          singular;
        logic          det_neg;
        logic [DW-1:0] det_mag;
        nval_t [8:0]   n;
    } div_in_t;

endpackage

// ----- rtl/svk_div.sv -----
// pipelined restoring divider lanes: sigma = N * 2^16 / det, saturated, one bit per stage
module svk_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  svk_pkg::div_in_t      din,
    output logic                  valid,
    output logic [8:0][31:0]      s,
    output logic                  singular
);
    import svk_pkg::*;

    // stage 0 = magnitude, stage 1 = overflow check, then NSTEP steps, then output
    logic [NSTEP+2:0] vd_reg;

    logic [NW-1:0] nm_reg [0:8];
    logic [NW-1:0] nm_next [0:8];
    logic [8:0]    ng1_reg;
    logic [8:0]    ng1_next;
    logic [DW-1:0] dq1_reg;
    logic          sing1_reg;

    logic [DW-1:0] rem_reg  [0:NSTEP][0:8];
    logic [31:0]   nlo_reg  [0:NSTEP][0:8];
    logic [QW-1:0] q_reg    [0:NSTEP][0:8];
    logic [8:0]    ng_reg   [0:NSTEP];
    logic [8:0]    ovf_reg  [0:NSTEP];
    logic [DW-1:0] dq_reg   [0:NSTEP];
    logic          sing_reg [0:NSTEP];

    logic [DW-1:0] rem0_next [0:8];
    logic [31:0]   nlo0_next [0:8];
    logic [8:0]    ovf0_next;

    logic [DW-1:0] rem_next [0:NSTEP-1][0:8];
    logic [QW-1:0] q_next   [0:NSTEP-1][0:8];

    logic [8:0][31:0] s_reg;
    logic [8:0][31:0] s_next;
    logic             sing_out_reg;

    always_comb
    begin
        for (int l = 0; l < 9; l++)
        begin
            nm_next[l]  = din.n[l][NW-1] ? NW'(-$signed(din.n[l])) : NW'(din.n[l]);
            ng1_next[l] = din.n[l][NW-1] ^ din.det_neg;
        end
    end

    // quotient fits in QW bits exactly when |N| < dq * 2^16
    always_comb
    begin
        for (int l = 0; l < 9; l++)
        begin
            ovf0_next[l] = nm_reg[l] >= NW'({dq1_reg, 16'h0000});
            rem0_next[l] = nm_reg[l][DW+15:16];
            nlo0_next[l] = {nm_reg[l][15:0], 16'h0000};
        end
    end

    always_comb
    begin
        logic [DW:0] r2;
        logic        ge;
        for (int k = 0; k < NSTEP; k++)
        begin
            for (int l = 0; l < 9; l++)
            begin
                r2 = {rem_reg[k][l], nlo_reg[k][l][31]};
                ge = r2 >= {1'b0, dq_reg[k]};
                rem_next[k][l] = ge ? DW'(r2 - {1'b0, dq_reg[k]}) : r2[DW-1:0];
                q_next[k][l]   = {q_reg[k][l][QW-2:0], ge};
            end
        end
    end

    always_comb
    begin
        logic [QW-1:0] q;
        logic          ng;
        for (int l = 0; l < 9; l++)
        begin
            q  = q_reg[NSTEP][l];
            ng = ng_reg[NSTEP][l];
            if (sing_reg[NSTEP])
                s_next[l] = '0;
            else if (ovf_reg[NSTEP][l])
                s_next[l] = ng ? SAT_MIN : SAT_MAX;
            else if (!ng)
                s_next[l] = q[QW-1] ? SAT_MAX : q;
            else if (q > SAT_MIN)
                s_next[l] = SAT_MIN;
            else
                s_next[l] = QW'(-q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd_reg <= '0;
        else if (adv)
            vd_reg <= {vd_reg[NSTEP+1:0], din.valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 9; l++)
            begin
                nm_reg[l]     <= nm_next[l];
                rem_reg[0][l] <= rem0_next[l];
                nlo_reg[0][l] <= nlo0_next[l];
                q_reg[0][l]   <= '0;
            end
            ng1_reg     <= ng1_next;
            dq1_reg     <= din.det_mag;
            sing1_reg   <= din.singular;
            ng_reg[0]   <= ng1_reg;
            ovf_reg[0]  <= ovf0_next;
            dq_reg[0]   <= dq1_reg;
            sing_reg[0] <= sing1_reg;
            for (int k = 0; k < NSTEP; k++)
            begin
                for (int l = 0; l < 9; l++)
                begin
                    rem_reg[k+1][l] <= rem_next[k][l];
                    nlo_reg[k+1][l] <= {nlo_reg[k][l][30:0], 1'b0};
                    q_reg[k+1][l]   <= q_next[k][l];
                end
                ng_reg[k+1]   <= ng_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
                dq_reg[k+1]   <= dq_reg[k];
                sing_reg[k+1] <= sing_reg[k];
            end
            s_reg        <= s_next;
            sing_out_reg <= sing_reg[NSTEP];
        end
    end

    assign valid    = vd_reg[NSTEP+2];
    assign s        = s_reg;
    assign singular = sing_out_reg;

endmodule

// ----- rtl/svk_cauchy_stress_top.sv -----
// St. Venant-Kirchhoff Cauchy stress pipeline: strain, stress, F*S*F^T, determinant
// throughput: one tensor per cycle while the output is not stalled; 10 arithmetic stages feed a divider that makes
// one quotient bit per stage (32 stages) for all nine entries in parallel
// reset: valid bits and both Lame constants clear to zero; no clearing pass
// stalls hold the whole pipeline; an empty first stage still takes a new tensor
module svk_cauchy_stress_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] f_xx,
    input  logic [31:0] f_xy,
    input  logic [31:0] f_xz,
    input  logic [31:0] f_yx,
    input  logic [31:0] f_yy,
    input  logic [31:0] f_yz,
    input  logic [31:0] f_zx,
    input  logic [31:0] f_zy,
    input  logic [31:0] f_zz,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] s_xx,
    output logic [31:0] s_xy,
    output logic [31:0] s_xz,
    output logic [31:0] s_yx,
    output logic [31:0] s_yy,
    output logic [31:0] s_yz,
    output logic [31:0] s_zx,
    output logic [31:0] s_zy,
    output logic [31:0] s_zz,
    output logic        singular,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import svk_pkg::*;

    localparam logic signed [65:0] ONE_Q32 = 66'sh1_0000_0000;

    logic [30:0] lame_lambda_reg;
    logic [30:0] lame_mu_reg;

    logic        adv;
    logic        ld1;
    logic [10:1] v_reg;

    logic signed [FW-1:0] f_in  [0:8];
    logic signed [FW-1:0] f_reg [1:8][0:8];

    // stage 1
    logic signed [63:0] cpp_reg [0:26];
    logic signed [63:0] cpp_next [0:26];
    logic signed [63:0] mp_reg [0:5];
    logic signed [63:0] mp_next [0:5];
    // stage 2
    logic signed [EW-1:0] e_reg [0:8];
    logic signed [EW-1:0] e_next [0:8];
    logic signed [MW-1:0] minor_reg [0:2];
    logic signed [MW-1:0] minor_next [0:2];
    // stage 3
    logic signed [58:0]   mlo_reg [0:8];
    logic signed [58:0]   mlo_next [0:8];
    logic signed [56:0]   mhi_reg [0:8];
    logic signed [56:0]   mhi_next [0:8];
    logic signed [TW-1:0] tr_reg;
    logic signed [TW-1:0] tr_next;
    logic signed [64:0]   dlo_reg [0:2];
    logic signed [64:0]   dlo_next [0:2];
    logic signed [64:0]   dhi_reg [0:2];
    logic signed [64:0]   dhi_next [0:2];
    // stage 4
    logic signed [MTW-1:0] mt4_reg [0:8];
    logic signed [MTW-1:0] mt4_next [0:8];
    logic signed [58:0]    llo_reg;
    logic signed [58:0]    llo_next;
    logic signed [56:0]    lhi_reg;
    logic signed [56:0]    lhi_next;
    logic signed [DTW-1:0] dt_reg [0:2];
    logic signed [DTW-1:0] dt_next [0:2];
    // stage 5
    logic signed [MTW-1:0]  mt5_reg [0:8];
    logic signed [LTW-1:0]  lt_reg;
    logic signed [LTW-1:0]  lt_next;
    logic signed [DETW-1:0] det_reg;
    logic signed [DETW-1:0] det_next;
    // stage 6
    logic signed [SW-1:0] s6_reg [0:8];
    logic signed [SW-1:0] s6_next [0:8];
    logic [DW-1:0]        dq_reg [6:10];
    logic [DW-1:0]        dq_next;
    logic [10:6]          dneg_reg;
    logic [10:6]          sing_reg;
    // stage 7
    logic signed [66:0] psl_reg [0:26];
    logic signed [66:0] psl_next [0:26];
    logic signed [65:0] psh_reg [0:26];
    logic signed [65:0] psh_next [0:26];
    // stage 8
    logic signed [FSW-1:0] fs_reg [0:8];
    logic signed [FSW-1:0] fs_next [0:8];
    // stage 9
    logic signed [60:0] pn0_reg [0:26];
    logic signed [60:0] pn0_next [0:26];
    logic signed [60:0] pn1_reg [0:26];
    logic signed [60:0] pn1_next [0:26];
    logic signed [59:0] pn2_reg [0:26];
    logic signed [59:0] pn2_next [0:26];
    // stage 10
    logic signed [NW-1:0] n_reg [0:8];
    logic signed [NW-1:0] n_next [0:8];

    div_in_t          div_in;
    logic             div_valid;
    logic [8:0][31:0] s_arr;
    logic             div_singular;

    // configuration port
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lame_lambda_reg <= '0;
            lame_mu_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LAMBDA: lame_lambda_reg <= cfg_data[30:0];
                REG_MU:     lame_mu_reg     <= cfg_data[30:0];
                default:    ;
            endcase
        end
    end

    // flow control
    assign adv      = !div_valid || out_ready;
    assign ld1      = adv || !v_reg[1];
    assign in_ready = ld1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (ld1)
                v_reg[1] <= in_valid;
            if (adv)
                v_reg[10:2] <= v_reg[9:1];
        end
    end

    always_comb
    begin
        f_in[0] = f_xx; f_in[1] = f_xy; f_in[2] = f_xz;
        f_in[3] = f_yx; f_in[4] = f_yy; f_in[5] = f_yz;
        f_in[6] = f_zx; f_in[7] = f_zy; f_in[8] = f_zz;
    end

    // stage 1: F^T F products and 2x2 minor products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                for (int k = 0; k < 3; k++)
                    cpp_next[(i*3+j)*3+k] = f_in[k*3+i] * f_in[k*3+j];
        mp_next[0] = f_in[4] * f_in[8];
        mp_next[1] = f_in[5] * f_in[7];
        mp_next[2] = f_in[3] * f_in[8];
        mp_next[3] = f_in[5] * f_in[6];
        mp_next[4] = f_in[3] * f_in[7];
        mp_next[5] = f_in[4] * f_in[6];
    end

    // stage 2: Green-Lagrange strain, minors
    always_comb
    begin
        logic signed [65:0] acc;
        for (int e = 0; e < 9; e++)
        begin
            acc = 66'(cpp_reg[e*3]) + 66'(cpp_reg[e*3+1]) + 66'(cpp_reg[e*3+2]);
            if (e == 0 || e == 4 || e == 8)
                acc = acc - ONE_Q32;
            e_next[e] = acc[65:17];
        end
        for (int k = 0; k < 3; k++)
            minor_next[k] = MW'(mp_reg[2*k]) - MW'(mp_reg[2*k+1]);
    end

    // stage 3: 2*mu*E partial products, trace, cofactor partial products
    always_comb
    begin
        for (int e = 0; e < 9; e++)
        begin
            mlo_next[e] = $signed({1'b0, lame_mu_reg, 1'b0}) * $signed({1'b0, e_reg[e][24:0]});
            mhi_next[e] = $signed({1'b0, lame_mu_reg, 1'b0}) * $signed(e_reg[e][EW-1:25]);
        end
        tr_next = TW'(e_reg[0]) + TW'(e_reg[4]) + TW'(e_reg[8]);
        for (int k = 0; k < 3; k++)
        begin
            dlo_next[k] = f_reg[2][k] * $signed({1'b0, minor_reg[k][31:0]});
            dhi_next[k] = f_reg[2][k] * $signed(minor_reg[k][MW-1:32]);
        end
    end

    // stage 4
    always_comb
    begin
        for (int e = 0; e < 9; e++)
            mt4_next[e] = (MTW'(mhi_reg[e]) <<< 25) + MTW'(mlo_reg[e]);
        llo_next = $signed({1'b0, lame_lambda_reg}) * $signed({1'b0, tr_reg[25:0]});
        lhi_next = $signed({1'b0, lame_lambda_reg}) * $signed(tr_reg[TW-1:26]);
        for (int k = 0; k < 3; k++)
            dt_next[k] = (DTW'(dhi_reg[k]) <<< 32) + DTW'(dlo_reg[k]);
    end

    // stage 5
    always_comb
    begin
        lt_next  = (LTW'(lhi_reg) <<< 26) + LTW'(llo_reg);
        det_next = DETW'(dt_reg[0]) - DETW'(dt_reg[1]) + DETW'(dt_reg[2]);
    end

    // stage 6: S and truncated determinant magnitude
    always_comb
    begin
        logic signed [SAW-1:0] acc;
        logic [DETW-1:0]       mag;
        for (int e = 0; e < 9; e++)
        begin
            acc = SAW'(mt5_reg[e]);
            if (e == 0 || e == 4 || e == 8)
                acc = acc + SAW'(lt_reg);
            s6_next[e] = acc[SAW-1:16];
        end
        mag     = det_reg[DETW-1] ? DETW'(-det_reg) : DETW'(det_reg);
        dq_next = mag[DW+31:32];
    end

    // stage 7: F*S partial products, S cut in two
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                for (int k = 0; k < 3; k++)
                begin
                    psl_next[(i*3+j)*3+k] = f_reg[6][i*3+k] * $signed({1'b0, s6_reg[k*3+j][33:0]});
                    psh_next[(i*3+j)*3+k] = f_reg[6][i*3+k] * $signed(s6_reg[k*3+j][SW-1:34]);
                end
    end

    // stage 8
    always_comb
    begin
        logic signed [FSAW-1:0] acc;
        for (int e = 0; e < 9; e++)
        begin
            acc = '0;
            for (int k = 0; k < 3; k++)
                acc = acc + (FSAW'(psh_reg[e*3+k]) <<< 34) + FSAW'(psl_reg[e*3+k]);
            fs_next[e] = acc[FSAW-1:16];
        end
    end

    // stage 9: FS*F^T partial products, FS cut in three
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                for (int k = 0; k < 3; k++)
                begin
                    pn0_next[(i*3+j)*3+k] = f_reg[8][j*3+k] * $signed({1'b0, fs_reg[i*3+k][27:0]});
                    pn1_next[(i*3+j)*3+k] = f_reg[8][j*3+k] * $signed({1'b0, fs_reg[i*3+k][55:28]});
                    pn2_next[(i*3+j)*3+k] = f_reg[8][j*3+k] * $signed(fs_reg[i*3+k][FSW-1:56]);
                end
    end

    // stage 10
    always_comb
    begin
        logic signed [NAW-1:0] acc;
        for (int e = 0; e < 9; e++)
        begin
            acc = '0;
            for (int k = 0; k < 3; k++)
                acc = acc + (NAW'(pn2_reg[e*3+k]) <<< 56) + (NAW'(pn1_reg[e*3+k]) <<< 28)
                    + NAW'(pn0_reg[e*3+k]);
            n_next[e] = acc[NAW-1:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            for (int e = 0; e < 9; e++)
                f_reg[1][e] <= f_in[e];
            for (int e = 0; e < 27; e++)
                cpp_reg[e] <= cpp_next[e];
            for (int e = 0; e < 6; e++)
                mp_reg[e] <= mp_next[e];
        end
        if (adv)
        begin
            for (int st = 2; st <= 8; st++)
                for (int e = 0; e < 9; e++)
                    f_reg[st][e] <= f_reg[st-1][e];
            for (int e = 0; e < 9; e++)
            begin
                e_reg[e]   <= e_next[e];
                mlo_reg[e] <= mlo_next[e];
                mhi_reg[e] <= mhi_next[e];
                mt4_reg[e] <= mt4_next[e];
                mt5_reg[e] <= mt4_reg[e];
                s6_reg[e]  <= s6_next[e];
                fs_reg[e]  <= fs_next[e];
                n_reg[e]   <= n_next[e];
            end
            for (int k = 0; k < 3; k++)
            begin
                minor_reg[k] <= minor_next[k];
                dlo_reg[k]   <= dlo_next[k];
                dhi_reg[k]   <= dhi_next[k];
                dt_reg[k]    <= dt_next[k];
            end
            for (int e = 0; e < 27; e++)
            begin
                psl_reg[e] <= psl_next[e];
                psh_reg[e] <= psh_next[e];
                pn0_reg[e] <= pn0_next[e];
                pn1_reg[e] <= pn1_next[e];
                pn2_reg[e] <= pn2_next[e];
            end
            tr_reg      <= tr_next;
            llo_reg     <= llo_next;
            lhi_reg     <= lhi_next;
            lt_reg      <= lt_next;
            det_reg     <= det_next;
            dq_reg[6]   <= dq_next;
            dneg_reg[6] <= det_reg[DETW-1];
            sing_reg[6] <= dq_next == '0;
            for (int st = 7; st <= 10; st++)
                dq_reg[st] <= dq_reg[st-1];
            dneg_reg[10:7] <= dneg_reg[9:6];
            sing_reg[10:7] <= sing_reg[9:6];
        end
    end

    always_comb
    begin
        div_in.valid    = v_reg[10];
        div_in.singular = sing_reg[10];
        div_in.det_neg  = dneg_reg[10];
        div_in.det_mag  = dq_reg[10];
        for (int e = 0; e < 9; e++)
            div_in.n[e] = n_reg[e];
    end

    svk_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .din      (div_in),
        .valid    (div_valid),
        .s        (s_arr),
        .singular (div_singular)
    );

    assign out_valid = div_valid;
    assign singular  = div_singular;
    assign s_xx = s_arr[0];
    assign s_xy = s_arr[1];
    assign s_xz = s_arr[2];
    assign s_yx = s_arr[3];
    assign s_yy = s_arr[4];
    assign s_yz = s_arr[5];
    assign s_zx = s_arr[6];
    assign s_zy = s_arr[7];
    assign s_zz = s_arr[8];

endmodule

// ----- test/svk_cauchy_stress_top_test.sv -----
// self-checking testbench for the St. Venant-Kirchhoff Cauchy stress pipeline
`timescale 1ns / 100ps

module svk_cauchy_stress_top_test;
    import svk_pkg::*;

    localparam logic [7:0] REG_UNUSED = 8'd2;
    localparam int ONE_Q = 65536;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_PER_PHASE = 400;

    typedef logic signed [255:0] wide_t;
    typedef logic [31:0] tensor_t [9];
    typedef struct {
        logic [31:0] s [9];
        logic        sing;
    } stress_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] f [9];
    logic        out_valid;
    logic        out_ready;
    logic [31:0] s [9];
    logic        singular;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [31:0] cfg_data;

    tensor_t     pending_f [$];
    stress_t     expected_stress [$];
    logic [30:0] lambda_q;
    logic [30:0] mu_q;
    int          idle_pct;
    logic        hold_req;
    logic        hold_done;
    int          hold_cnt;
    int          mismatches;
    int          quiet_cycles;
    logic        in_ready_seen;

    svk_cauchy_stress_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .f_xx(f[0]), .f_xy(f[1]), .f_xz(f[2]),
        .f_yx(f[3]), .f_yy(f[4]), .f_yz(f[5]),
        .f_zx(f[6]), .f_zy(f[7]), .f_zz(f[8]),
        .out_valid(out_valid), .out_ready(out_ready),
        .s_xx(s[0]), .s_xy(s[1]), .s_xz(s[2]),
        .s_yx(s[3]), .s_yy(s[4]), .s_yz(s[5]),
        .s_zx(s[6]), .s_zy(s[7]), .s_zz(s[8]),
        .singular(singular),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // full-width fixed-point stress, truncations as the pipeline does them
    function automatic stress_t predict_stress(input tensor_t fin);
        wide_t   fm [3][3];
        wide_t   e [3][3];
        wide_t   sm [3][3];
        wide_t   fs [3][3];
        wide_t   acc;
        wide_t   tr;
        wide_t   lam;
        wide_t   mu2;
        wide_t   det;
        wide_t   detq;
        wide_t   scale32;
        wide_t   q;
        wide_t   lim;
        stress_t r;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                fm[i][j] = $signed(fin[i*3+j]);
        scale32 = 1;
        scale32 = scale32 <<< 32;
        lim = 1;
        lim = lim <<< 31;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc = acc + fm[k][i] * fm[k][j];
                if (i == j)
                    acc = acc - scale32;
                e[i][j] = acc >>> 17;
            end
        tr = e[0][0] + e[1][1] + e[2][2];
        lam = 0;
        lam[30:0] = lambda_q;
        mu2 = 0;
        mu2[30:0] = mu_q;
        mu2 = mu2 <<< 1;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                acc = mu2 * e[i][j];
                if (i == j)
                    acc = acc + lam * tr;
                sm[i][j] = acc >>> 16;
            end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc = acc + fm[i][k] * sm[k][j];
                fs[i][j] = acc >>> 16;
            end
        det = fm[0][0] * (fm[1][1] * fm[2][2] - fm[1][2] * fm[2][1])
            - fm[0][1] * (fm[1][0] * fm[2][2] - fm[1][2] * fm[2][0])
            + fm[0][2] * (fm[1][0] * fm[2][1] - fm[1][1] * fm[2][0]);
        detq = det / scale32;
        r.sing = (detq == 0);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                if (r.sing)
                begin
                    r.s[i*3+j] = 32'h0;
                end
                else
                begin
                    acc = 0;
                    for (int k = 0; k < 3; k++)
                        acc = acc + fs[i][k] * fm[j][k];
                    acc = acc >>> 16;
                    q = (acc <<< 16) / detq;
                    if (q >= lim)
                        r.s[i*3+j] = SAT_MAX;
                    else if (q < -lim)
                        r.s[i*3+j] = SAT_MIN;
                    else
                        r.s[i*3+j] = q[31:0];
                end
            end
        return r;
    endfunction

    // input side: present the head of the queue, hold it until the transfer
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready_seen)
        begin
            if (pending_f.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                in_valid <= 1'b1;
                for (int i = 0; i < 9; i++)
                    f[i] <= pending_f[0][i];
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // output side: random stalls plus one long hold-off
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_cnt <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            out_ready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end
        else if (hold_req && !hold_done)
        begin
            out_ready <= 1'b0;
            hold_cnt <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // sample transfers, predict, check
    always @(posedge clk or negedge rst_n)
    begin
        stress_t got;
        stress_t want;
        logic    bad;
        if (!rst_n)
        begin
            in_ready_seen <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            in_ready_seen <= in_valid && in_ready;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_LAMBDA)
                    lambda_q = cfg_data[30:0];
                else if (cfg_index == REG_MU)
                    mu_q = cfg_data[30:0];
            end
            if (in_valid && in_ready)
            begin
                expected_stress.push_back(predict_stress(pending_f[0]));
                void'(pending_f.pop_front());
            end
            if (out_valid && out_ready)
            begin
                for (int i = 0; i < 9; i++)
                    got.s[i] = s[i];
                got.sing = singular;
                if (expected_stress.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer at %0t", $time);
                end
                else
                begin
                    want = expected_stress.pop_front();
                    bad = (got.sing !== want.sing);
                    for (int i = 0; i < 9; i++)
                        if (got.s[i] !== want.s[i])
                            bad = 1'b1;
                    if (bad)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("stress mismatch at %0t, singular exp %0b got %0b",
                                     $time, want.sing, got.sing);
                            for (int i = 0; i < 9; i++)
                                $display("  s[%0d] exp %h got %h", i, want.s[i], got.s[i]);
                        end
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_f.size() > 0 || expected_stress.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_diag(input int a, input int b, input int c);
        tensor_t t;
        for (int i = 0; i < 9; i++)
            t[i] = 32'h0;
        t[0] = a;
        t[4] = b;
        t[8] = c;
        pending_f.push_back(t);
    endtask

    task automatic push_fill(input logic [31:0] v);
        tensor_t t;
        for (int i = 0; i < 9; i++)
            t[i] = v;
        pending_f.push_back(t);
    endtask

    function automatic tensor_t random_tensor();
        tensor_t t;
        int      mode;
        int      span;
        mode = $urandom_range(99);
        span = (mode < 60) ? ONE_Q / 2 : 4 * ONE_Q;
        for (int i = 0; i < 9; i++)
        begin
            if (mode >= 85 && mode < 95)
                t[i] = $urandom();
            else if (mode >= 95)
                t[i] = $urandom_range(0, 128) - 64;
            else
                t[i] = ((i % 4 == 0) ? ONE_Q : 0) + $urandom_range(0, 2 * span) - span;
        end
        // rank-deficient: repeat a row
        if (mode >= 75 && mode < 85)
            for (int j = 0; j < 3; j++)
                t[6+j] = t[3+j];
        return t;
    endfunction

    task automatic random_phase(input int count);
        for (int n = 0; n < count; n++)
            pending_f.push_back(random_tensor());
    endtask

    initial
    begin
        tensor_t t;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_LAMBDA;
        cfg_data = 32'h0;
        for (int i = 0; i < 9; i++)
            f[i] = 32'h0;
        lambda_q = '0;
        mu_q = '0;
        idle_pct = 30;
        hold_req = 1'b0;
        mismatches = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: identity, extremes, singular and mirrored tensors
        write_reg(REG_LAMBDA, 32'h0001_8000);
        write_reg(REG_MU, 32'h0000_CCCC);
        push_diag(ONE_Q, ONE_Q, ONE_Q);
        push_fill(32'h0);
        push_fill(32'h7FFF_FFFF);
        push_fill(32'h8000_0000);
        push_fill(32'hFFFF_FFFF);
        push_diag(ONE_Q, ONE_Q, 1);
        push_diag(ONE_Q, ONE_Q, 32'h0001_0001);
        push_diag(-ONE_Q, ONE_Q, ONE_Q);
        push_diag(2 * ONE_Q, ONE_Q / 2, ONE_Q);
        push_diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_diag(ONE_Q / 256, ONE_Q / 256, ONE_Q);
        push_diag(ONE_Q / 1024, ONE_Q / 1024, ONE_Q / 1024);
        push_diag(ONE_Q / 2, ONE_Q / 2, ONE_Q / 2);
        for (int i = 0; i < 9; i++)
            t[i] = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        pending_f.push_back(t);
        for (int i = 0; i < 9; i++)
            t[i] = (i % 4 == 0) ? ONE_Q : ONE_Q / 4;
        pending_f.push_back(t);
        t[6] = t[0];
        t[7] = t[1];
        t[8] = t[2];
        pending_f.push_back(t);
        // simple shear
        push_diag(ONE_Q, ONE_Q, ONE_Q);
        pending_f[$][1] = ONE_Q / 2;
        wait_drained();

        // constants at reset-like zero, then extremes with the ignored top bit set
        write_reg(REG_LAMBDA, 32'h0);
        write_reg(REG_MU, 32'h0);
        random_phase(RANDOM_PER_PHASE);
        wait_drained();

        write_reg(REG_LAMBDA, 32'hFFFF_FFFF);
        write_reg(REG_MU, 32'hFFFF_FFFF);
        write_reg(REG_UNUSED, 32'h1234_5678);
        random_phase(RANDOM_PER_PHASE);
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        write_reg(REG_LAMBDA, 32'h0002_0000);
        write_reg(REG_MU, 32'h8000_8000);
        hold_req = 1'b1;
        random_phase(RANDOM_PER_PHASE);
        wait_drained();

        // no idling on either side
        write_reg(REG_LAMBDA, $urandom());
        write_reg(REG_MU, $urandom());
        idle_pct = 0;
        random_phase(RANDOM_PER_PHASE);
        wait_drained();

        idle_pct = 30;
        write_reg(REG_LAMBDA, 32'h7FFF_FFFF);
        write_reg(REG_MU, 32'h0000_0001);
        random_phase(RANDOM_PER_PHASE);
        wait_drained();

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
